// File: design/sedf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sedf_pkg;

  localparam int unsigned BYTE_W = 8;

  // Configuration register indexes
  localparam logic [BYTE_W-1:0] CFG_START_CODE = 8'd0;
  localparam logic [BYTE_W-1:0] CFG_END_CODE   = 8'd1;

  // Reset values of the configuration registers
  localparam logic [BYTE_W-1:0] START_CODE_RST = 8'h01;
  localparam logic [BYTE_W-1:0] END_CODE_RST   = 8'h03;

  // Source selection for the output register
  typedef enum logic [2:0] {
    LD_NONE,
    LD_START,
    LD_PAY,
    LD_END,
    LD_OVF
  } ld_sel_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic    clr_count;
    logic    store;
    logic    rd_req;
    logic    rd_clr;
    logic    rd_inc;
    ld_sel_e ld_sel;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic byte_zero;
    logic is_start;
    logic is_end;
    logic count_full;
    logic count_zero;
    logic rd_last;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

// File: design/sedf_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module sedf_datapath #(
  parameter int unsigned MAX_PAYLOAD = 62
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire  [sedf_pkg::BYTE_W-1:0]  rx_byte_i,
  input  wire                          cfg_we_i,
  input  wire  [sedf_pkg::BYTE_W-1:0]  cfg_index_i,
  input  wire  [sedf_pkg::BYTE_W-1:0]  cfg_data_i,
  input  sedf_pkg::cmd_t               cmd_i,
  output sedf_pkg::sts_t               sts_o,
  input  wire                          frame_ready_i,
  output logic                         frame_valid_o,
  output logic [sedf_pkg::BYTE_W-1:0]  frame_byte_o,
  output logic                         last_of_frame_o,
  output logic                         overflow_o
);
  import sedf_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_PAYLOAD + 1);
  localparam int unsigned IDX_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

  logic [BYTE_W-1:0] start_code_q, end_code_q;
  logic [CNT_W-1:0]  count_q, rd_idx_q;
  logic [BYTE_W-1:0] mem [MAX_PAYLOAD];
  logic [BYTE_W-1:0] rdata_q;
  logic              valid_q;
  logic [BYTE_W-1:0] byte_q;
  logic              last_q, ovf_q;
  logic              out_free;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_code_q <= START_CODE_RST;
      end_code_q   <= END_CODE_RST;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CFG_START_CODE) start_code_q <= cfg_data_i;
      if (cfg_index_i == CFG_END_CODE)   end_code_q   <= cfg_data_i;
    end
  end

  // Payload fill count and read pointer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      rd_idx_q <= '0;
    end else begin
      if (cmd_i.clr_count) count_q <= '0;
      else if (cmd_i.store) count_q <= CNT_W'(count_q + 1'b1);
      if (cmd_i.rd_clr) rd_idx_q <= '0;
      else if (cmd_i.rd_inc) rd_idx_q <= CNT_W'(rd_idx_q + 1'b1);
    end
  end

  // Payload store, registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.store) mem[count_q[IDX_W-1:0]] <= rx_byte_i;
    if (cmd_i.rd_req) rdata_q <= mem[rd_idx_q[IDX_W-1:0]];
  end

  // Output register: load on command, drop once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (cmd_i.ld_sel != LD_NONE) begin
      valid_q <= 1'b1;
    end else if (frame_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.ld_sel)
      LD_START: begin
        byte_q <= start_code_q; last_q <= 1'b0; ovf_q <= 1'b0;
      end
      LD_PAY: begin
        byte_q <= rdata_q; last_q <= 1'b0; ovf_q <= 1'b0;
      end
      LD_END: begin
        byte_q <= end_code_q; last_q <= 1'b1; ovf_q <= 1'b0;
      end
      LD_OVF: begin
        byte_q <= '0; last_q <= 1'b1; ovf_q <= 1'b1;
      end
      default: ;
    endcase
  end

  assign out_free = !valid_q || frame_ready_i;

  // Status towards the controller
  always_comb begin
    sts_o.byte_zero  = (rx_byte_i == '0);
    sts_o.is_start   = (rx_byte_i == start_code_q);
    sts_o.is_end     = (rx_byte_i == end_code_q);
    sts_o.count_full = (count_q == CNT_W'(MAX_PAYLOAD));
    sts_o.count_zero = (count_q == '0);
    sts_o.rd_last    = (CNT_W'(rd_idx_q + 1'b1) == count_q);
    sts_o.out_free   = out_free;
  end

  assign frame_valid_o   = valid_q;
  assign frame_byte_o    = byte_q;
  assign last_of_frame_o = last_q;
  assign overflow_o      = ovf_q;

endmodule

`default_nettype wire

// File: design/sedf_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module sedf_ctrl (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             rx_valid_i,
  output logic            rx_ready_o,
  input  sedf_pkg::sts_t  sts_i,
  output sedf_pkg::cmd_t  cmd_o
);
  import sedf_pkg::*;

  localparam logic [2:0] S_HUNT  = 3'd0;
  localparam logic [2:0] S_FRAME = 3'd1;
  localparam logic [2:0] S_START = 3'd2;
  localparam logic [2:0] S_PRD   = 3'd3;
  localparam logic [2:0] S_PLD   = 3'd4;
  localparam logic [2:0] S_END   = 3'd5;
  localparam logic [2:0] S_OVF   = 3'd6;

  logic [2:0] state_q, state_d;
  logic       take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_HUNT;
    else         state_q <= state_d;
  end

  assign rx_ready_o = (state_q == S_HUNT) || (state_q == S_FRAME);
  assign take       = rx_valid_i && rx_ready_o && !sts_i.byte_zero;

  // Sequence hunting, buffering and burst emission
  always_comb begin
    state_d = state_q;
    cmd_o   = '{clr_count: 1'b0, store: 1'b0, rd_req: 1'b0, rd_clr: 1'b0,
                rd_inc: 1'b0, ld_sel: LD_NONE};
    case (state_q)
      S_HUNT: begin
        if (take && sts_i.is_start) begin
          cmd_o.clr_count = 1'b1;
          state_d = S_FRAME;
        end
      end
      S_FRAME: begin
        if (take) begin
          if (sts_i.is_start) begin
            cmd_o.clr_count = 1'b1;
          end else if (sts_i.is_end) begin
            state_d = S_START;
          end else if (sts_i.count_full) begin
            state_d = S_OVF;
          end else begin
            cmd_o.store = 1'b1;
          end
        end
      end
      S_START: begin
        if (sts_i.out_free) begin
          cmd_o.ld_sel = LD_START;
          cmd_o.rd_clr = 1'b1;
          state_d = sts_i.count_zero ? S_END : S_PRD;
        end
      end
      S_PRD: begin
        cmd_o.rd_req = 1'b1;
        state_d = S_PLD;
      end
      S_PLD: begin
        if (sts_i.out_free) begin
          cmd_o.ld_sel = LD_PAY;
          cmd_o.rd_inc = 1'b1;
          state_d = sts_i.rd_last ? S_END : S_PRD;
        end
      end
      S_END: begin
        if (sts_i.out_free) begin
          cmd_o.ld_sel    = LD_END;
          cmd_o.clr_count = 1'b1;
          state_d = S_HUNT;
        end
      end
      S_OVF: begin
        if (sts_i.out_free) begin
          cmd_o.ld_sel    = LD_OVF;
          cmd_o.clr_count = 1'b1;
          state_d = S_HUNT;
        end
      end
      default: state_d = S_HUNT;
    endcase
  end

endmodule

`default_nettype wire

// File: design/start_end_code_deframer_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Start/end code deframer.
// Input channel rx_*: one received byte per transaction. Zero bytes are
// ignored. While hunting, bytes are dropped until the start code arrives;
// payload bytes are then buffered, a repeated start code restarts the frame.
// Output channel frame_*: on the end code the frame is sent as a burst of
// start code, payload and end code, last_of_frame marking the end code.
// A payload longer than MAX_PAYLOAD drops the frame and sends one result
// with overflow and last_of_frame set and a zero byte.
// Throughput: a byte that causes no result is taken every cycle. An end code
// holds the input off until the end code has been loaded; each payload byte
// passes a read state and a load state, since the memory read is registered.
// The start code is loaded from state S_START, once the output is free.
// Configuration: cfg_* writes the start code (index 0) and the end code
// (index 1), always ready; write only while idle.
// Reset: hunting, empty buffer, codes 0x01 and 0x03, no result pending.
// A stalled receiver holds the output register and freezes the burst.
module start_end_code_deframer_top #(
  parameter int unsigned MAX_PAYLOAD = 62
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          rx_valid_i,
  output logic                         rx_ready_o,
  input  wire  [sedf_pkg::BYTE_W-1:0]  rx_byte_i,
  input  wire                          cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire  [sedf_pkg::BYTE_W-1:0]  cfg_index_i,
  input  wire  [sedf_pkg::BYTE_W-1:0]  cfg_data_i,
  output logic                         frame_valid_o,
  input  wire                          frame_ready_i,
  output logic [sedf_pkg::BYTE_W-1:0]  frame_byte_o,
  output logic                         last_of_frame_o,
  output logic                         overflow_o
);
  import sedf_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  sedf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rx_valid_i (rx_valid_i),
    .rx_ready_o (rx_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  sedf_datapath #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .rx_byte_i       (rx_byte_i),
    .cfg_we_i        (cfg_valid_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .frame_ready_i   (frame_ready_i),
    .frame_valid_o   (frame_valid_o),
    .frame_byte_o    (frame_byte_o),
    .last_of_frame_o (last_of_frame_o),
    .overflow_o      (overflow_o)
  );

endmodule

`default_nettype wire

// File: design/sedf_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module sedf_checker (
  input wire       clk_i,
  input wire       rst_ni,
  input wire       rx_ready_o,
  input wire       frame_valid_o,
  input wire       frame_ready_i,
  input wire [7:0] frame_byte_o,
  input wire       last_of_frame_o,
  input wire       overflow_o
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_valid_o && !frame_ready_i |=> frame_valid_o && $stable(frame_byte_o))
    else $error("stalled result changed or vanished");

  // Overflow result is a last item with a zero byte
  a_ovf_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_valid_o && overflow_o |-> last_of_frame_o && (frame_byte_o == 8'h00))
    else $error("malformed overflow result");

  // Input is held off while a burst is still in progress
  a_burst_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_valid_o && !last_of_frame_o |-> !rx_ready_o)
    else $error("input accepted during frame burst");

endmodule

bind start_end_code_deframer_top sedf_checker u_sedf_checker (.*);

`default_nettype wire
